/* hdl/sfp_pkg.sv */
// Shared types and constants for the serial frame parser.
// Used by the channel interfaces, the CRC unit and the top level. No dependencies.
package sfp_pkg;

   localparam int ByteWidth         = 8;
   localparam int CrcWidth          = 16;
   localparam int TallyWidth        = 32;
   localparam int CountWidthDefault = 32;
   localparam int CsrIndexWidth     = 2;

   localparam logic [CrcWidth-1:0]  CrcInit = 16'hFFFF;
   localparam logic [CrcWidth-1:0]  CrcPoly = 16'hA001;

   localparam logic [ByteWidth-1:0] SyncFirstReset  = 8'hAA;
   localparam logic [ByteWidth-1:0] SyncSecondReset = 8'h55;
   localparam logic [ByteWidth-1:0] MaxLenReset     = 8'd64;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_SYNC_FIRST  = 2'd0,
      CSR_SYNC_SECOND = 2'd1,
      CSR_MAX_LEN     = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_SYNC1 = 3'd0,
      PH_SYNC2 = 3'd1,
      PH_ID    = 3'd2,
      PH_SEQ   = 3'd3,
      PH_LEN   = 3'd4,
      PH_DATA  = 3'd5,
      PH_CRCL  = 3'd6,
      PH_CRCH  = 3'd7
   } phase_type;

   typedef struct packed {
      logic                  data_valid;
      logic [ByteWidth-1:0]  data_byte;
      logic [ByteWidth-1:0]  data_index;
      logic                  frame_good;
      logic                  crc_error;
      logic [ByteWidth-1:0]  msg_id;
      logic [ByteWidth-1:0]  seq_num;
      logic [ByteWidth-1:0]  payload_len;
      logic [TallyWidth-1:0] resync_count;
      logic [TallyWidth-1:0] bad_len_count;
      logic [TallyWidth-1:0] crc_err_count;
      logic [TallyWidth-1:0] frame_count;
   } result_type;

endpackage

/* hdl/sfp_channels.sv */
// Valid/ready channel interfaces for the serial frame parser: byte in, result out, CSR write.
// Depends on sfp_pkg.
interface sfp_req_if;
   import sfp_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface sfp_rsp_if;
   import sfp_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  data_valid;
   logic [ByteWidth-1:0]  data_byte;
   logic [ByteWidth-1:0]  data_index;
   logic                  frame_good;
   logic                  crc_error;
   logic [ByteWidth-1:0]  msg_id;
   logic [ByteWidth-1:0]  seq_num;
   logic [ByteWidth-1:0]  payload_len;
   logic [TallyWidth-1:0] resync_count;
   logic [TallyWidth-1:0] bad_len_count;
   logic [TallyWidth-1:0] crc_err_count;
   logic [TallyWidth-1:0] frame_count;

   modport source (output valid, output data_valid, output data_byte, output data_index,
                   output frame_good, output crc_error, output msg_id, output seq_num,
                   output payload_len, output resync_count, output bad_len_count,
                   output crc_err_count, output frame_count, input ready);
   modport sink   (input valid, input data_valid, input data_byte, input data_index,
                   input frame_good, input crc_error, input msg_id, input seq_num,
                   input payload_len, input resync_count, input bad_len_count,
                   input crc_err_count, input frame_count, output ready);
endinterface

interface sfp_csr_if;
   import sfp_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [CsrIndexWidth-1:0] index;
   logic [ByteWidth-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/sfp_crc_byte.sv */
// One-byte update of the reflected CRC16/Modbus (poly 0xA001).
// Combinational; depends on sfp_pkg.
module sfp_crc_byte (
   input  logic [sfp_pkg::CrcWidth-1:0]  crc_cur,
   input  logic [sfp_pkg::ByteWidth-1:0] data,
   output logic [sfp_pkg::CrcWidth-1:0]  crc_next
);
   import sfp_pkg::*;

   logic [CrcWidth-1:0] c;

   always_comb begin
      c = crc_cur ^ {{(CrcWidth-ByteWidth){1'b0}}, data};
      for (int k = 0; k < ByteWidth; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CrcPoly;
         end else begin
            c = c >> 1;
         end
      end
      crc_next = c;
   end

endmodule

/* hdl/serial_frame_parser_crc16.sv */
// Serial frame parser: sync hunt, header, streamed payload, CRC16/Modbus check.
// Depends on sfp_pkg, sfp_channels and sfp_crc_byte.
//
// Use:
//   req_bus  carries one received byte per transaction (in_byte).
//   rsp_bus  returns exactly one result per accepted byte: the payload byte
//            and its index when the byte was payload, frame good / CRC error
//            on the last CRC byte, the current header fields and the four
//            event counters after that byte.
//   csr_bus  writes sync_first (0), sync_second (1) and max_payload_len (2);
//            always ready, other indices are ignored.
// Result: the result of a byte is on rsp_bus in the cycle after it is taken.
// Throughput: one byte per cycle while results are taken; the parser state and the CRC byte update
//   sit between the input handshake and a single result register.
// Reset: parser back to the first-sync hunt, counters and CRC cleared,
//   registers to 0xAA, 0x55 and 64, no result pending.
// Stall: while a result waits and rsp_bus.ready is low, req_bus.ready is low;
//   a byte is taken in the same cycle the waiting result leaves.
// Counters are COUNT_WIDTH bits wide and wrap; the low 32 bits are shown.
module serial_frame_parser_crc16 #(
   parameter int COUNT_WIDTH = sfp_pkg::CountWidthDefault
) (
   input  logic      clock,
   input  logic      reset,
   sfp_req_if.sink   req_bus,
   sfp_rsp_if.source rsp_bus,
   sfp_csr_if.sink   csr_bus
);
   import sfp_pkg::*;

   localparam int WideWidth = (COUNT_WIDTH > TallyWidth) ? COUNT_WIDTH : TallyWidth;

   logic [ByteWidth-1:0]   sync_first_ff, sync_second_ff, max_len_ff;

   phase_type              phase_ff, phase_in;
   logic [CrcWidth-1:0]    crc_ff, crc_in, crc_upd;
   logic [ByteWidth-1:0]   crc_low_ff, crc_low_in;
   logic [ByteWidth-1:0]   msg_id_ff, msg_id_in;
   logic [ByteWidth-1:0]   seq_ff, seq_in;
   logic [ByteWidth-1:0]   len_ff, len_in;
   logic [ByteWidth-1:0]   index_ff, index_in, index_inc;
   logic [COUNT_WIDTH-1:0] resync_ff, resync_in;
   logic [COUNT_WIDTH-1:0] bad_len_ff, bad_len_in;
   logic [COUNT_WIDTH-1:0] crc_err_ff, crc_err_in;
   logic [COUNT_WIDTH-1:0] good_ff, good_in;

   logic                   rsp_valid_ff;
   result_type             rsp_ff, rsp_in;

   logic                   accept;
   logic [ByteWidth-1:0]   b;
   logic [WideWidth-1:0]   resync_w, bad_len_w, crc_err_w, good_w;

   assign b             = req_bus.in_byte;
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign index_inc     = index_ff + ByteWidth'(1);

   sfp_crc_byte u_crc (
      .crc_cur  (crc_ff),
      .data     (b),
      .crc_next (crc_upd)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= SyncFirstReset;
         sync_second_ff <= SyncSecondReset;
         max_len_ff     <= MaxLenReset;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_SYNC_FIRST:  sync_first_ff  <= csr_bus.data;
            CSR_SYNC_SECOND: sync_second_ff <= csr_bus.data;
            CSR_MAX_LEN:     max_len_ff     <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // next state and result for the byte on req_bus
   always_comb begin
      phase_in   = phase_ff;
      crc_in     = crc_ff;
      crc_low_in = crc_low_ff;
      msg_id_in  = msg_id_ff;
      seq_in     = seq_ff;
      len_in     = len_ff;
      index_in   = index_ff;
      resync_in  = resync_ff;
      bad_len_in = bad_len_ff;
      crc_err_in = crc_err_ff;
      good_in    = good_ff;
      rsp_in     = '0;

      unique case (phase_ff)
         PH_SYNC1: begin
            if (b == sync_first_ff) begin
               phase_in = PH_SYNC2;
            end else begin
               resync_in = resync_ff + COUNT_WIDTH'(1);
            end
         end
         PH_SYNC2: begin
            if (b == sync_second_ff) begin
               phase_in = PH_ID;
               crc_in   = CrcInit;
            end else if (b == sync_first_ff) begin
               resync_in = resync_ff + COUNT_WIDTH'(1);
            end else begin
               resync_in = resync_ff + COUNT_WIDTH'(1);
               phase_in  = PH_SYNC1;
            end
         end
         PH_ID: begin
            msg_id_in = b;
            crc_in    = crc_upd;
            phase_in  = PH_SEQ;
         end
         PH_SEQ: begin
            seq_in   = b;
            crc_in   = crc_upd;
            phase_in = PH_LEN;
         end
         PH_LEN: begin
            len_in   = b;
            crc_in   = crc_upd;
            index_in = '0;
            if (b > max_len_ff) begin
               bad_len_in = bad_len_ff + COUNT_WIDTH'(1);
               phase_in   = PH_SYNC1;
            end else if (b == '0) begin
               phase_in = PH_CRCL;
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            rsp_in.data_valid = 1'b1;
            rsp_in.data_byte  = b;
            rsp_in.data_index = index_ff;
            crc_in            = crc_upd;
            index_in          = index_inc;
            if (index_inc >= len_ff) begin
               phase_in = PH_CRCL;
            end
         end
         PH_CRCL: begin
            crc_low_in = b;
            phase_in   = PH_CRCH;
         end
         PH_CRCH: begin
            phase_in = PH_SYNC1;
            if ({b, crc_low_ff} == crc_ff) begin
               good_in           = good_ff + COUNT_WIDTH'(1);
               rsp_in.frame_good = 1'b1;
            end else begin
               crc_err_in       = crc_err_ff + COUNT_WIDTH'(1);
               rsp_in.crc_error = 1'b1;
            end
         end
      endcase

      resync_w  = WideWidth'(resync_in);
      bad_len_w = WideWidth'(bad_len_in);
      crc_err_w = WideWidth'(crc_err_in);
      good_w    = WideWidth'(good_in);

      rsp_in.msg_id        = msg_id_in;
      rsp_in.seq_num       = seq_in;
      rsp_in.payload_len   = len_in;
      rsp_in.resync_count  = resync_w[TallyWidth-1:0];
      rsp_in.bad_len_count = bad_len_w[TallyWidth-1:0];
      rsp_in.crc_err_count = crc_err_w[TallyWidth-1:0];
      rsp_in.frame_count   = good_w[TallyWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SYNC1;
         crc_ff     <= '0;
         crc_low_ff <= '0;
         msg_id_ff  <= '0;
         seq_ff     <= '0;
         len_ff     <= '0;
         index_ff   <= '0;
         resync_ff  <= '0;
         bad_len_ff <= '0;
         crc_err_ff <= '0;
         good_ff    <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         crc_ff     <= crc_in;
         crc_low_ff <= crc_low_in;
         msg_id_ff  <= msg_id_in;
         seq_ff     <= seq_in;
         len_ff     <= len_in;
         index_ff   <= index_in;
         resync_ff  <= resync_in;
         bad_len_ff <= bad_len_in;
         crc_err_ff <= crc_err_in;
         good_ff    <= good_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.data_valid    = rsp_ff.data_valid;
   assign rsp_bus.data_byte     = rsp_ff.data_byte;
   assign rsp_bus.data_index    = rsp_ff.data_index;
   assign rsp_bus.frame_good    = rsp_ff.frame_good;
   assign rsp_bus.crc_error     = rsp_ff.crc_error;
   assign rsp_bus.msg_id        = rsp_ff.msg_id;
   assign rsp_bus.seq_num       = rsp_ff.seq_num;
   assign rsp_bus.payload_len   = rsp_ff.payload_len;
   assign rsp_bus.resync_count  = rsp_ff.resync_count;
   assign rsp_bus.bad_len_count = rsp_ff.bad_len_count;
   assign rsp_bus.crc_err_count = rsp_ff.crc_err_count;
   assign rsp_bus.frame_count   = rsp_ff.frame_count;

endmodule

/* sim/serial_frame_parser_crc16_test.sv */
// Self-checking testbench for serial_frame_parser_crc16: directed byte table, then random
// framed traffic under several sync / length settings, checked against a local parser model.
// Depends on sfp_pkg, sfp_channels and the parser RTL.
`timescale 1ns / 100ps

module serial_frame_parser_crc16_test;
   import sfp_pkg::*;

   localparam int HoldCycles  = 300;
   localparam int DrainLimit  = 20000;
   localparam logic [CsrIndexWidth-1:0] CsrIndexUnused = 2'd3;

   typedef enum logic [1:0] {
      ROW_BYTE,
      ROW_CRC_LOW,
      ROW_CRC_HIGH,
      ROW_CRC_WRONG
   } row_kind_type;

   typedef struct {
      row_kind_type         kind;
      logic [ByteWidth-1:0] value;
      bit                   fixed;
      result_type           want;
   } stim_row_type;

   logic clock;
   logic reset;

   sfp_req_if req_bus();
   sfp_rsp_if rsp_bus();
   sfp_csr_if csr_bus();

   serial_frame_parser_crc16 uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // parser model state
   phase_type             cur_phase;
   logic [CrcWidth-1:0]   cur_crc;
   logic [ByteWidth-1:0]  crc_low_seen;
   logic [ByteWidth-1:0]  hdr_id;
   logic [ByteWidth-1:0]  hdr_seq;
   logic [ByteWidth-1:0]  hdr_len;
   logic [ByteWidth-1:0]  pay_index;
   logic [TallyWidth-1:0] resync_n;
   logic [TallyWidth-1:0] bad_len_n;
   logic [TallyWidth-1:0] crc_err_n;
   logic [TallyWidth-1:0] good_n;
   logic [ByteWidth-1:0]  cfg_sync_first;
   logic [ByteWidth-1:0]  cfg_sync_second;
   logic [ByteWidth-1:0]  cfg_max_len;

   result_type   frame_results_q[$];
   stim_row_type directed_rows[$];
   int           mismatch_count = 0;
   int           bytes_sent     = 0;
   bit           idle_en        = 1'b1;
   bit           hold_req       = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [CrcWidth-1:0] crc16_update(input logic [CrcWidth-1:0] crc,
                                                        input logic [ByteWidth-1:0] b);
      logic [CrcWidth-1:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) c = (c >> 1) ^ CrcPoly;
         else      c = c >> 1;
      end
      return c;
   endfunction

   task automatic parse_byte(input logic [ByteWidth-1:0] b, output result_type r);
      r = '0;
      case (cur_phase)
         PH_SYNC1: begin
            if (b == cfg_sync_first) cur_phase = PH_SYNC2;
            else resync_n++;
         end
         PH_SYNC2: begin
            if (b == cfg_sync_second) begin
               cur_phase = PH_ID;
               cur_crc   = CrcInit;
            end else begin
               resync_n++;
               if (b != cfg_sync_first) cur_phase = PH_SYNC1;
            end
         end
         PH_ID: begin
            hdr_id    = b;
            cur_crc   = crc16_update(cur_crc, b);
            cur_phase = PH_SEQ;
         end
         PH_SEQ: begin
            hdr_seq   = b;
            cur_crc   = crc16_update(cur_crc, b);
            cur_phase = PH_LEN;
         end
         PH_LEN: begin
            hdr_len   = b;
            cur_crc   = crc16_update(cur_crc, b);
            pay_index = '0;
            if (b > cfg_max_len) begin
               bad_len_n++;
               cur_phase = PH_SYNC1;
            end else if (b == 0) begin
               cur_phase = PH_CRCL;
            end else begin
               cur_phase = PH_DATA;
            end
         end
         PH_DATA: begin
            r.data_valid = 1'b1;
            r.data_byte  = b;
            r.data_index = pay_index;
            cur_crc      = crc16_update(cur_crc, b);
            pay_index++;
            if (pay_index >= hdr_len) cur_phase = PH_CRCL;
         end
         PH_CRCL: begin
            crc_low_seen = b;
            cur_phase    = PH_CRCH;
         end
         default: begin
            cur_phase = PH_SYNC1;
            if ({b, crc_low_seen} == cur_crc) begin
               good_n++;
               r.frame_good = 1'b1;
            end else begin
               crc_err_n++;
               r.crc_error = 1'b1;
            end
         end
      endcase
      r.msg_id        = hdr_id;
      r.seq_num       = hdr_seq;
      r.payload_len   = hdr_len;
      r.resync_count  = resync_n;
      r.bad_len_count = bad_len_n;
      r.crc_err_count = crc_err_n;
      r.frame_count   = good_n;
   endtask

   function automatic result_type hdr_result(input int id, input int seq,
                                             input int len, input int rs, input int bl);
      result_type r;
      r = '0;
      r.msg_id        = 8'(id);
      r.seq_num       = 8'(seq);
      r.payload_len   = 8'(len);
      r.resync_count  = 32'(rs);
      r.bad_len_count = 32'(bl);
      return r;
   endfunction

   function automatic stim_row_type stim_row(input row_kind_type kind, input logic [7:0] value,
                                             input bit fixed, input result_type want);
      stim_row_type s;
      s.kind  = kind;
      s.value = value;
      s.fixed = fixed;
      s.want  = want;
      return s;
   endfunction

   function automatic int pick_len(input int cap);
      int r;
      r = $urandom_range(0, 29);
      if (r == 0) return int'(cfg_max_len);
      if (r == 1) return $urandom_range(0, int'(cfg_max_len));
      return $urandom_range(0, (int'(cfg_max_len) < cap) ? int'(cfg_max_len) : cap);
   endfunction

   task automatic offer_byte(input logic [ByteWidth-1:0] b, input bit fixed,
                             input result_type fixed_want);
      result_type predicted;
      if (idle_en && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.in_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      parse_byte(b, predicted);
      frame_results_q.push_back(fixed ? fixed_want : predicted);
      bytes_sent++;
   endtask

   task automatic feed(input logic [ByteWidth-1:0] b);
      offer_byte(b, 1'b0, '0);
   endtask

   task automatic write_csr(input logic [CsrIndexWidth-1:0] idx, input logic [ByteWidth-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CSR_SYNC_FIRST:  cfg_sync_first  = value;
         CSR_SYNC_SECOND: cfg_sync_second = value;
         CSR_MAX_LEN:     cfg_max_len     = value;
         default: ;
      endcase
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_bus.valid <= 1'b0;
      while (frame_results_q.size() != 0 && guard < DrainLimit) begin
         @(posedge clock);
         guard++;
      end
      repeat (3) @(posedge clock);
   endtask

   task automatic run_traffic(input int budget);
      int start;
      int kind;
      int len;
      int cut;
      start = bytes_sent;
      while (bytes_sent - start < budget) begin
         kind = $urandom_range(0, 9);
         if (kind == 7) begin
            repeat ($urandom_range(1, 6)) feed(8'($urandom_range(0, 255)));
         end else if (kind == 8) begin
            feed(cfg_sync_first);
            case ($urandom_range(0, 2))
               0: feed(8'($urandom_range(0, 255)));
               1: begin
                  feed(cfg_sync_second);
                  feed(8'($urandom_range(0, 255)));
                  feed(8'($urandom_range(0, 255)));
                  if (cfg_max_len < 8'hFF) feed(8'($urandom_range(cfg_max_len + 1, 255)));
                  else feed(8'($urandom_range(0, 255)));
               end
               default: begin
                  feed(cfg_sync_second);
                  feed(8'($urandom_range(0, 255)));
                  feed(8'($urandom_range(0, 255)));
                  len = pick_len(6);
                  feed(8'(len));
                  cut = (len > 0) ? $urandom_range(0, len - 1) : 0;
                  repeat (cut) feed(8'($urandom_range(0, 255)));
               end
            endcase
         end else begin
            feed(cfg_sync_first);
            if (kind == 9) repeat ($urandom_range(1, 3)) feed(cfg_sync_first);
            feed(cfg_sync_second);
            feed(8'($urandom_range(0, 255)));
            feed(8'($urandom_range(0, 255)));
            len = pick_len(6);
            feed(8'(len));
            repeat (len) feed(8'($urandom_range(0, 255)));
            feed(cur_crc[7:0]);
            if ($urandom_range(0, 5) == 0) feed(cur_crc[15:8] ^ 8'($urandom_range(1, 255)));
            else feed(cur_crc[15:8]);
         end
      end
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end else if (idle_en && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (frame_results_q.size() == 0) begin
            $error("result transaction with nothing expected");
            mismatch_count++;
         end else begin
            want = frame_results_q.pop_front();
            check_field("data_valid",  32'(want.data_valid),  32'(rsp_bus.data_valid));
            check_field("data_byte",   32'(want.data_byte),   32'(rsp_bus.data_byte));
            check_field("data_index",  32'(want.data_index),  32'(rsp_bus.data_index));
            check_field("frame_good",  32'(want.frame_good),  32'(rsp_bus.frame_good));
            check_field("crc_error",   32'(want.crc_error),   32'(rsp_bus.crc_error));
            check_field("msg_id",      32'(want.msg_id),      32'(rsp_bus.msg_id));
            check_field("seq_num",     32'(want.seq_num),     32'(rsp_bus.seq_num));
            check_field("payload_len", 32'(want.payload_len), 32'(rsp_bus.payload_len));
            check_field("resync_count",  want.resync_count,  rsp_bus.resync_count);
            check_field("bad_len_count", want.bad_len_count, rsp_bus.bad_len_count);
            check_field("crc_err_count", want.crc_err_count, rsp_bus.crc_err_count);
            check_field("frame_count",   want.frame_count,   rsp_bus.frame_count);
         end
      end
   end

   initial begin
      logic [ByteWidth-1:0] b;
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.in_byte <= '0;
      csr_bus.valid   <= 1'b0;
      csr_bus.index   <= '0;
      csr_bus.data    <= '0;

      cur_phase       = PH_SYNC1;
      cur_crc         = '0;
      crc_low_seen    = '0;
      hdr_id          = '0;
      hdr_seq         = '0;
      hdr_len         = '0;
      pay_index       = '0;
      resync_n        = '0;
      bad_len_n       = '0;
      crc_err_n       = '0;
      good_n          = '0;
      cfg_sync_first  = SyncFirstReset;
      cfg_sync_second = SyncSecondReset;
      cfg_max_len     = MaxLenReset;

      // hunt, overlapping sync, length too large, wrong second byte,
      // zero-length good frame, two-byte frame with bad CRC
      directed_rows.push_back(stim_row(ROW_BYTE, 8'h00, 1'b1, hdr_result(0, 0, 0, 1, 0)));
      directed_rows.push_back(stim_row(ROW_BYTE, 8'hFF, 1'b1, hdr_result(0, 0, 0, 2, 0)));
      directed_rows.push_back(stim_row(ROW_BYTE, 8'hAA, 1'b1, hdr_result(0, 0, 0, 2, 0)));
      directed_rows.push_back(stim_row(ROW_BYTE, 8'hAA, 1'b1, hdr_result(0, 0, 0, 3, 0)));
      directed_rows.push_back(stim_row(ROW_BYTE, 8'h55, 1'b1, hdr_result(0, 0, 0, 3, 0)));
      directed_rows.push_back(stim_row(ROW_BYTE, 8'h01, 1'b0, '0));
      directed_rows.push_back(stim_row(ROW_BYTE, 8'h02, 1'b0, '0));
      directed_rows.push_back(stim_row(ROW_BYTE, 8'h41, 1'b1, hdr_result(1, 2, 65, 3, 1)));
      directed_rows.push_back(stim_row(ROW_BYTE, 8'hAA, 1'b1, hdr_result(1, 2, 65, 3, 1)));
      directed_rows.push_back(stim_row(ROW_BYTE, 8'h13, 1'b1, hdr_result(1, 2, 65, 4, 1)));
      directed_rows.push_back(stim_row(ROW_BYTE, 8'hAA, 1'b0, '0));
      directed_rows.push_back(stim_row(ROW_BYTE, 8'h55, 1'b0, '0));
      directed_rows.push_back(stim_row(ROW_BYTE, 8'hFF, 1'b0, '0));
      directed_rows.push_back(stim_row(ROW_BYTE, 8'h00, 1'b0, '0));
      directed_rows.push_back(stim_row(ROW_BYTE, 8'h00, 1'b0, '0));
      directed_rows.push_back(stim_row(ROW_CRC_LOW, 8'h00, 1'b0, '0));
      directed_rows.push_back(stim_row(ROW_CRC_HIGH, 8'h00, 1'b0, '0));
      directed_rows.push_back(stim_row(ROW_BYTE, 8'hAA, 1'b0, '0));
      directed_rows.push_back(stim_row(ROW_BYTE, 8'h55, 1'b0, '0));
      directed_rows.push_back(stim_row(ROW_BYTE, 8'h7E, 1'b0, '0));
      directed_rows.push_back(stim_row(ROW_BYTE, 8'h80, 1'b0, '0));
      directed_rows.push_back(stim_row(ROW_BYTE, 8'h02, 1'b0, '0));
      directed_rows.push_back(stim_row(ROW_BYTE, 8'h00, 1'b0, '0));
      directed_rows.push_back(stim_row(ROW_BYTE, 8'hFF, 1'b0, '0));
      directed_rows.push_back(stim_row(ROW_CRC_LOW, 8'h00, 1'b0, '0));
      directed_rows.push_back(stim_row(ROW_CRC_WRONG, 8'h00, 1'b0, '0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         case (directed_rows[i].kind)
            ROW_CRC_LOW:   b = cur_crc[7:0];
            ROW_CRC_HIGH:  b = cur_crc[15:8];
            ROW_CRC_WRONG: b = ~cur_crc[15:8];
            default:       b = directed_rows[i].value;
         endcase
         offer_byte(b, directed_rows[i].fixed, directed_rows[i].want);
      end

      // reset settings, with a long receiver hold-off part way in
      run_traffic(50);
      hold_req = 1'b1;
      run_traffic(100);

      // equal sync bytes, zero maximum length; parser possibly left mid-frame
      drain();
      write_csr(CSR_SYNC_FIRST, 8'h3C);
      write_csr(CSR_SYNC_SECOND, 8'h3C);
      write_csr(CSR_MAX_LEN, 8'h00);
      write_csr(CsrIndexUnused, 8'hFF);
      run_traffic(80);

      // extreme sync values, full length range
      drain();
      write_csr(CSR_SYNC_FIRST, 8'h00);
      write_csr(CSR_SYNC_SECOND, 8'hFF);
      write_csr(CSR_MAX_LEN, 8'hFF);
      run_traffic(120);

      // random settings, no idling on either side
      drain();
      idle_en = 1'b0;
      write_csr(CSR_SYNC_FIRST, 8'($urandom_range(0, 255)));
      write_csr(CSR_SYNC_SECOND, 8'($urandom_range(0, 255)));
      write_csr(CSR_MAX_LEN, 8'($urandom_range(1, 255)));
      run_traffic(120);

      drain();
      if (frame_results_q.size() != 0) begin
         $error("%0d expected result transaction(s) never arrived", frame_results_q.size());
         mismatch_count++;
      end
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
